// File: rtl/ppr_pkg.sv
// Shared types and constants for the printer packet receiver.
// Used by the channel interfaces and by the receiver module; depends on nothing.

package ppr_pkg;

   // Most data packets the printer holds before it reports overflow.
   localparam int unsigned MaxPackets = 10;

   localparam int unsigned ByteW   = 8;
   localparam int unsigned WordW   = 16;
   localparam int unsigned ActionW = 3;
   localparam int unsigned SlotW   = 4;

   localparam logic [ByteW-1:0] MAGIC_ONE = 8'h88;
   localparam logic [ByteW-1:0] MAGIC_TWO = 8'h33;
   localparam logic [ByteW-1:0] ACK_BYTE  = 8'h81;
   localparam logic [ByteW-1:0] CMD_INIT  = 8'h01;
   localparam logic [ByteW-1:0] CMD_PRINT = 8'h02;
   localparam logic [ByteW-1:0] CMD_DATA  = 8'h04;

   localparam logic [ActionW-1:0] ACT_NONE  = 3'd0;
   localparam logic [ActionW-1:0] ACT_INIT  = 3'd1;
   localparam logic [ActionW-1:0] ACT_PRINT = 3'd2;
   localparam logic [ActionW-1:0] ACT_STORE = 3'd3;
   localparam logic [ActionW-1:0] ACT_DROP  = 3'd4;

   localparam logic [SlotW-1:0] MAX_SLOT = SlotW'(MaxPackets);

   // One result transaction.
   typedef struct packed {
      logic [ByteW-1:0]   reply_byte;
      logic               payload_valid;
      logic [ByteW-1:0]   payload_byte;
      logic               packet_done;
      logic [ByteW-1:0]   command_code;
      logic [ByteW-1:0]   compressed_flag;
      logic               sum_matched;
      logic [ActionW-1:0] action;
      logic [SlotW-1:0]   packet_slot;
   } result_type;

endpackage

// File: rtl/ppr_stream_if.sv
// Valid/ready channel interfaces for the printer packet receiver.
// Depends on ppr_pkg for field widths.

interface ppr_req_if;
   logic                         valid;
   logic                         ready;
   logic [ppr_pkg::ByteW-1:0]    tx_byte;

   modport source (output valid, output tx_byte, input ready);
   modport sink (input valid, input tx_byte, output ready);
endinterface

interface ppr_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ppr_pkg::ByteW-1:0]    reply_byte;
   logic                         payload_valid;
   logic [ppr_pkg::ByteW-1:0]    payload_byte;
   logic                         packet_done;
   logic [ppr_pkg::ByteW-1:0]    command_code;
   logic [ppr_pkg::ByteW-1:0]    compressed_flag;
   logic                         sum_matched;
   logic [ppr_pkg::ActionW-1:0]  action;
   logic [ppr_pkg::SlotW-1:0]    packet_slot;

   modport source (
      output valid, output reply_byte, output payload_valid, output payload_byte,
      output packet_done, output command_code, output compressed_flag,
      output sum_matched, output action, output packet_slot, input ready
   );
   modport sink (
      input valid, input reply_byte, input payload_valid, input payload_byte,
      input packet_done, input command_code, input compressed_flag,
      input sum_matched, input action, input packet_slot, output ready
   );
endinterface

// File: rtl/printer_packet_receiver.sv
// Printer packet receiver: deframes the console's serial byte stream into packets.
// Depends on ppr_pkg and on the channel interfaces in ppr_stream_if.sv.
//
// Usage:
//   The req channel carries one console byte (tx_byte) per transaction. For each
//   one the rsp channel returns exactly one transaction with the printer's reply
//   byte and the decoded packet information: payload bytes are flagged with
//   payload_valid, and the fourth trailer byte raises packet_done together with
//   the command, compression byte, checksum match, action and packet count.
//   A byte goes first into an input register. When the result register is empty
//   or being drained, the packet decoder works on it, updates the packet state
//   and loads the result register, from which rsp offers the result.
//   Throughput is one byte per cycle unless rsp stalls: the input register
//   accepts a new byte whenever its current byte moves on to the result register.
//   When the receiver stalls rsp, the result register holds its transaction, the
//   input register fills, and only then does req.ready fall; no byte is lost.
//   Synchronous reset empties both registers and returns the decoder to hunting
//   for the first magic byte with all counts and sums cleared, including the
//   stored packet count.

module printer_packet_receiver (
   input logic          clock,
   input logic          reset,
   ppr_req_if.sink      req,
   ppr_rsp_if.source    rsp
);

   localparam logic [2:0] PH_HUNT1 = 3'd0;
   localparam logic [2:0] PH_HUNT2 = 3'd1;
   localparam logic [2:0] PH_CMD   = 3'd2;
   localparam logic [2:0] PH_COMP  = 3'd3;
   localparam logic [2:0] PH_LENLO = 3'd4;
   localparam logic [2:0] PH_LENHI = 3'd5;
   localparam logic [2:0] PH_DATA  = 3'd6;
   localparam logic [2:0] PH_TRAIL = 3'd7;

   // Input register.
   logic                         in_valid_ff;
   logic [ppr_pkg::ByteW-1:0]    in_byte_ff;

   // Result register.
   logic                         out_valid_ff;
   ppr_pkg::result_type          result_ff;
   ppr_pkg::result_type          result_in;

   // Packet state.
   logic [2:0]                   phase_ff, phase_in;
   logic [ppr_pkg::ByteW-1:0]    cmd_ff, cmd_in;
   logic [ppr_pkg::ByteW-1:0]    comp_ff, comp_in;
   logic [ppr_pkg::WordW-1:0]    length_ff, length_in;
   logic [ppr_pkg::WordW-1:0]    count_ff, count_in;
   logic [ppr_pkg::WordW-1:0]    sum_ff, sum_in;
   logic [ppr_pkg::WordW-1:0]    trailer_ff, trailer_in;
   logic [ppr_pkg::SlotW-1:0]    stored_ff, stored_in;

   logic                         advance;
   logic                         fire;
   logic [ppr_pkg::WordW-1:0]    sum_plus;
   logic [ppr_pkg::WordW-1:0]    count_plus;
   logic [ppr_pkg::WordW-1:0]    new_length;
   logic                         sums_equal;

   // The input register moves on whenever the result register is empty or
   // being drained in this cycle.
   assign advance   = !out_valid_ff || rsp.ready;
   assign fire      = in_valid_ff && advance;
   assign req.ready = !in_valid_ff || advance;

   assign sum_plus   = sum_ff + {{(ppr_pkg::WordW - ppr_pkg::ByteW){1'b0}}, in_byte_ff};
   assign count_plus = count_ff + 1'b1;
   assign new_length = {in_byte_ff, length_ff[ppr_pkg::ByteW-1:0]};
   assign sums_equal = (sum_ff == trailer_ff);

   always_comb begin
      phase_in   = phase_ff;
      cmd_in     = cmd_ff;
      comp_in    = comp_ff;
      length_in  = length_ff;
      count_in   = count_ff;
      sum_in     = sum_ff;
      trailer_in = trailer_ff;
      stored_in  = stored_ff;
      result_in  = '0;

      case (phase_ff)
         PH_HUNT1: begin
            if (in_byte_ff == ppr_pkg::MAGIC_ONE) begin
               phase_in = PH_HUNT2;
            end
         end
         PH_HUNT2: begin
            // A wrong second byte is not taken as a new first magic byte.
            phase_in = (in_byte_ff == ppr_pkg::MAGIC_TWO) ? PH_CMD : PH_HUNT1;
         end
         PH_CMD: begin
            cmd_in   = in_byte_ff;
            sum_in   = {{(ppr_pkg::WordW - ppr_pkg::ByteW){1'b0}}, in_byte_ff};
            phase_in = PH_COMP;
         end
         PH_COMP: begin
            comp_in  = in_byte_ff;
            sum_in   = sum_plus;
            phase_in = PH_LENLO;
         end
         PH_LENLO: begin
            length_in = {{(ppr_pkg::WordW - ppr_pkg::ByteW){1'b0}}, in_byte_ff};
            sum_in    = sum_plus;
            phase_in  = PH_LENHI;
         end
         PH_LENHI: begin
            length_in = new_length;
            sum_in    = sum_plus;
            count_in  = '0;
            // An empty packet goes straight to the trailer.
            phase_in  = (new_length != '0) ? PH_DATA : PH_TRAIL;
         end
         PH_DATA: begin
            result_in.payload_valid = 1'b1;
            result_in.payload_byte  = in_byte_ff;
            sum_in                  = sum_plus;
            if (count_plus == length_ff) begin
               count_in = '0;
               phase_in = PH_TRAIL;
            end else begin
               count_in = count_plus;
            end
         end
         default: begin
            // Trailer: checksum low, checksum high, ack slot, status slot.
            if (count_ff == 16'd0) begin
               trailer_in = {{(ppr_pkg::WordW - ppr_pkg::ByteW){1'b0}}, in_byte_ff};
            end else if (count_ff == 16'd1) begin
               trailer_in = {in_byte_ff, trailer_ff[ppr_pkg::ByteW-1:0]};
            end else if (count_ff == 16'd2) begin
               if (sums_equal) begin
                  result_in.reply_byte = ppr_pkg::ACK_BYTE;
               end
            end
            if (count_ff >= 16'd3) begin
               result_in.packet_done     = 1'b1;
               result_in.command_code    = cmd_ff;
               result_in.compressed_flag = comp_ff;
               result_in.sum_matched     = sums_equal;
               if (cmd_ff == ppr_pkg::CMD_INIT) begin
                  stored_in        = '0;
                  result_in.action = ppr_pkg::ACT_INIT;
               end else if (cmd_ff == ppr_pkg::CMD_PRINT) begin
                  result_in.action = ppr_pkg::ACT_PRINT;
               end else if (cmd_ff == ppr_pkg::CMD_DATA) begin
                  if (stored_ff < ppr_pkg::MAX_SLOT) begin
                     stored_in        = stored_ff + 1'b1;
                     result_in.action = ppr_pkg::ACT_STORE;
                  end else begin
                     result_in.action = ppr_pkg::ACT_DROP;
                  end
               end
               result_in.packet_slot = stored_in;
               count_in              = '0;
               phase_in              = PH_HUNT1;
            end else begin
               count_in = count_plus;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_HUNT1;
         cmd_ff       <= '0;
         comp_ff      <= '0;
         length_ff    <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         trailer_ff   <= '0;
         stored_ff    <= '0;
      end else begin
         if (req.valid && req.ready) begin
            in_valid_ff <= 1'b1;
         end else if (fire) begin
            in_valid_ff <= 1'b0;
         end
         if (fire) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
         if (fire) begin
            phase_ff   <= phase_in;
            cmd_ff     <= cmd_in;
            comp_ff    <= comp_in;
            length_ff  <= length_in;
            count_ff   <= count_in;
            sum_ff     <= sum_in;
            trailer_ff <= trailer_in;
            stored_ff  <= stored_in;
         end
      end
   end

   // Payload registers carry no reset; the valid bits qualify them.
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_byte_ff <= req.tx_byte;
      end
      if (fire) begin
         result_ff <= result_in;
      end
   end

   assign rsp.valid           = out_valid_ff;
   assign rsp.reply_byte      = result_ff.reply_byte;
   assign rsp.payload_valid   = result_ff.payload_valid;
   assign rsp.payload_byte    = result_ff.payload_byte;
   assign rsp.packet_done     = result_ff.packet_done;
   assign rsp.command_code    = result_ff.command_code;
   assign rsp.compressed_flag = result_ff.compressed_flag;
   assign rsp.sum_matched     = result_ff.sum_matched;
   assign rsp.action          = result_ff.action;
   assign rsp.packet_slot     = result_ff.packet_slot;

`ifndef SYNTHESIS
   // The packet count never passes the limit.
   a_stored_limit: assert property (@(posedge clock) disable iff (reset)
      stored_ff <= ppr_pkg::MAX_SLOT)
      else $error("stored packet count above limit");

   // A payload byte never completes a packet.
   a_payload_not_done: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && result_ff.payload_valid) |-> !result_ff.packet_done)
      else $error("payload byte flagged as packet end");

   // Only the acknowledge code is ever returned besides zero.
   a_reply_code: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && result_ff.reply_byte != '0) |->
         (result_ff.reply_byte == ppr_pkg::ACK_BYTE && !result_ff.packet_done))
      else $error("unexpected reply byte");

   // A byte held in the input register while the output stalls stays there.
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_byte_ff)))
      else $error("input byte lost during stall");

   // The decoder only changes state when a byte is processed.
   a_state_quiet: assert property (@(posedge clock) disable iff (reset)
      !fire |=> ($stable(phase_ff) && $stable(sum_ff) && $stable(stored_ff)))
      else $error("packet state changed without a byte");
`endif

endmodule
